// File: src/phb_pkg.sv
package phb_pkg;

   localparam int SYMBOLS         = 256;
   localparam int MAX_KEY_SYMBOLS = 4;
   localparam int MAX_KEYS        = 1024;
   localparam int MAX_VERTICES    = 4096;

   localparam int SYM_W   = $clog2(SYMBOLS);
   localparam int POS_W   = $clog2(MAX_KEY_SYMBOLS);
   localparam int WADDR_W = POS_W + SYM_W;
   localparam int VADDR_W = $clog2(MAX_VERTICES);
   localparam int EADDR_W = $clog2(MAX_KEYS);
   localparam int WEIGHT_W = 12;
   localparam int SUM_W   = 14;
   localparam int VALUE_W = 10;

   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_WEIGHT = 3'd1;
   localparam logic [2:0] CMD_INSERT = 3'd2;
   localparam logic [2:0] CMD_FINAL  = 3'd3;
   localparam logic [2:0] CMD_LOOKUP = 3'd4;

   localparam logic [2:0] STAT_DONE   = 3'd0;
   localparam logic [2:0] STAT_INSERT = 3'd1;
   localparam logic [2:0] STAT_CYCLE  = 3'd2;
   localparam logic [2:0] STAT_FULL   = 3'd3;
   localparam logic [2:0] STAT_LOOKUP = 3'd4;

   localparam logic [1:0] REG_KEY_COUNT    = 2'd0;
   localparam logic [1:0] REG_VERTEX_COUNT = 2'd1;
   localparam logic [1:0] REG_KEY_LENGTH   = 2'd2;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [VADDR_W-1:0] sid;
      logic               lnk_v;
      logic [VADDR_W-1:0] lnk;
      logic               reached;
   } vertex_type;

   typedef struct packed {
      logic               pending;
      logic [VADDR_W-1:0] a;
      logic [VADDR_W-1:0] b;
   } edge_type;

endpackage

// File: src/phb_req_if.sv
interface phb_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [7:0] symbol;
   logic [1:0] position;
   logic       table_select;
   logic [11:0] weight;

   modport source (output valid, command, symbol, position, table_select, weight,
                   input ready);
   modport sink (input valid, command, symbol, position, table_select, weight,
                 output ready);
endinterface

// File: src/phb_rsp_if.sv
interface phb_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [9:0] key_index;

   modport source (output valid, status, key_index, input ready);
   modport sink (input valid, status, key_index, output ready);
endinterface

// File: src/perfect_hash_builder_lookup_unit.sv
// Minimal perfect hash builder and lookup engine. One transaction is handled at a time, and
// a result may wait on the response channel while the next transaction is taken. A key
// symbol that is not the last of its key only adds its weights to the sums; the last
// symbol adds a remainder step that maps the sums onto vertices. A lookup then reads both
// vertex values and adds them modulo the key count. An insert walks the two chains of its
// endpoints vertex by vertex, since all vertex state sits in one memory with a single read
// and a single write port. Finalize sweeps the vertex memory, then makes passes over the
// edges, resolving each edge that still waits; passes repeat until one changes nothing or
// a pass limit is reached. After reset and after a clear the vertex memory is swept, and
// no request transaction is accepted during the sweep; register writes are taken at all
// times.
module perfect_hash_builder_lookup_unit (
   input  logic        clock,
   input  logic        reset,
   phb_req_if.sink     req,
   phb_rsp_if.source   rsp,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam logic [4:0] ST_CLR    = 5'd0;
   localparam logic [4:0] ST_IDLE   = 5'd1;
   localparam logic [4:0] ST_SYM    = 5'd2;
   localparam logic [4:0] ST_KMOD   = 5'd3;
   localparam logic [4:0] ST_L_RV   = 5'd4;
   localparam logic [4:0] ST_L_GET  = 5'd5;
   localparam logic [4:0] ST_L_MOD  = 5'd6;
   localparam logic [4:0] ST_I_RV   = 5'd7;
   localparam logic [4:0] ST_I_WU   = 5'd8;
   localparam logic [4:0] ST_I_WV   = 5'd9;
   localparam logic [4:0] ST_I_END  = 5'd10;
   localparam logic [4:0] ST_I_REL  = 5'd11;
   localparam logic [4:0] ST_F_INIT = 5'd12;
   localparam logic [4:0] ST_F_ERD  = 5'd13;
   localparam logic [4:0] ST_F_EA   = 5'd14;
   localparam logic [4:0] ST_F_VB   = 5'd15;
   localparam logic [4:0] ST_F_DEC  = 5'd16;
   localparam logic [4:0] ST_F_MOD  = 5'd17;
   localparam logic [4:0] ST_OUT    = 5'd18;

   localparam int CNT_W  = phb_pkg::VADDR_W + 1;
   localparam int ECNT_W = phb_pkg::EADDR_W + 1;

   logic [4:0]  state_ff, state_in;
   logic [10:0] key_count_ff, key_count_in;
   logic [12:0] vertex_count_ff, vertex_count_in;
   logic [2:0]  key_length_ff, key_length_in;
   logic [10:0] kc_eff;
   logic [12:0] vc_eff;
   logic [2:0]  len_eff;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             clr_reply_ff, clr_reply_in;
   logic [2:0]       cmd_ff, cmd_in;
   logic [phb_pkg::SUM_W-1:0] sum1_ff, sum1_in, sum2_ff, sum2_in;
   logic [phb_pkg::SUM_W-1:0] ns1, ns2;
   logic [2:0]       pos_ff, pos_in;
   logic [ECNT_W-1:0] edge_count_ff, edge_count_in;
   logic [phb_pkg::VADDR_W-1:0] u_ff, u_in, v_ff, v_in, hu_ff, hu_in, hv_ff, hv_in;
   logic [phb_pkg::VADDR_W-1:0] cur_ff, cur_in;
   phb_pkg::vertex_type eu_ff, eu_in, ev_ff, ev_in, va_ff, va_in;
   phb_pkg::edge_type   ee_ff, ee_in;
   logic             tgt_ff, tgt_in;
   logic [ECNT_W-1:0] ei_ff, ei_in, pass_ff, pass_in;
   logic             first_ff, first_in, changed_ff, changed_in;
   logic [2:0]       out_status_ff, out_status_in;
   logic [9:0]       out_index_ff, out_index_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff;
   logic [9:0]       rsp_index_ff;
   logic             rsp_load;

   logic [1:0][phb_pkg::SUM_W-1:0] mx_ff, mx_in;
   logic [1:0][12:0] mr_ff, mr_in;
   logic [12:0]      md_ff, md_in;
   logic [3:0]       mcnt_ff, mcnt_in;
   logic             mod_start;
   logic [phb_pkg::SUM_W-1:0] mod_x0, mod_x1;
   logic [12:0]      mod_d;
   logic [phb_pkg::SUM_W-1:0] mstep;
   logic [11:0]      msum, mres;

   phb_pkg::vertex_type vert_mem [0:phb_pkg::MAX_VERTICES-1];
   phb_pkg::vertex_type v_rd_ff, v_wr_data;
   logic                v_rd_en, v_wr_en;
   logic [phb_pkg::VADDR_W-1:0] v_rd_addr, v_wr_addr;

   phb_pkg::edge_type   edge_mem [0:phb_pkg::MAX_KEYS-1];
   phb_pkg::edge_type   e_rd_ff, e_wr_data;
   logic                e_rd_en, e_wr_en;
   logic [phb_pkg::EADDR_W-1:0] e_rd_addr, e_wr_addr;

   logic [phb_pkg::WEIGHT_W-1:0] wa_mem [0:phb_pkg::MAX_KEY_SYMBOLS*phb_pkg::SYMBOLS-1];
   logic [phb_pkg::WEIGHT_W-1:0] wb_mem [0:phb_pkg::MAX_KEY_SYMBOLS*phb_pkg::SYMBOLS-1];
   logic [phb_pkg::WEIGHT_W-1:0] wa_rd_ff, wb_rd_ff;
   logic                w_rd_en, wa_wr_en, wb_wr_en;
   logic [phb_pkg::WADDR_W-1:0] w_rd_addr, w_wr_addr;

   logic cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel & penable & pwrite;

   always_comb begin
      case (paddr[3:2])
         phb_pkg::REG_KEY_COUNT:    prdata = {21'd0, key_count_ff};
         phb_pkg::REG_VERTEX_COUNT: prdata = {19'd0, vertex_count_ff};
         phb_pkg::REG_KEY_LENGTH:   prdata = {29'd0, key_length_ff};
         default:                   prdata = 32'd0;
      endcase
   end

   always_comb begin
      key_count_in    = key_count_ff;
      vertex_count_in = vertex_count_ff;
      key_length_in   = key_length_ff;
      if (cfg_write) begin
         case (paddr[3:2])
            phb_pkg::REG_KEY_COUNT:    key_count_in    = pwdata[10:0];
            phb_pkg::REG_VERTEX_COUNT: vertex_count_in = pwdata[12:0];
            phb_pkg::REG_KEY_LENGTH:   key_length_in   = pwdata[2:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (key_count_ff == 11'd0) begin
         kc_eff = 11'd1;
      end else if (key_count_ff > 11'(phb_pkg::MAX_KEYS)) begin
         kc_eff = 11'(phb_pkg::MAX_KEYS);
      end else begin
         kc_eff = key_count_ff;
      end
      if (vertex_count_ff == 13'd0) begin
         vc_eff = 13'd1;
      end else if (vertex_count_ff > 13'(phb_pkg::MAX_VERTICES)) begin
         vc_eff = 13'(phb_pkg::MAX_VERTICES);
      end else begin
         vc_eff = vertex_count_ff;
      end
      if (key_length_ff == 3'd0) begin
         len_eff = 3'd1;
      end else if (key_length_ff > 3'(phb_pkg::MAX_KEY_SYMBOLS)) begin
         len_eff = 3'(phb_pkg::MAX_KEY_SYMBOLS);
      end else begin
         len_eff = key_length_ff;
      end
   end

   // Restoring remainder, one dividend bit per cycle on two lanes.
   always_comb begin
      mx_in   = mx_ff;
      mr_in   = mr_ff;
      md_in   = md_ff;
      mcnt_in = mcnt_ff;
      mstep   = '0;
      if (mod_start) begin
         mx_in[0] = mod_x0;
         mx_in[1] = mod_x1;
         mr_in   = '0;
         md_in   = mod_d;
         mcnt_in = 4'(phb_pkg::SUM_W);
      end else if (mcnt_ff != 4'd0) begin
         for (int k = 0; k < 2; k++) begin
            mstep = {mr_ff[k], mx_ff[k][phb_pkg::SUM_W-1]};
            if (mstep >= {1'b0, md_ff}) begin
               mstep = mstep - {1'b0, md_ff};
            end
            mr_in[k] = mstep[12:0];
            mx_in[k] = {mx_ff[k][phb_pkg::SUM_W-2:0], 1'b0};
         end
         mcnt_in = mcnt_ff - 4'd1;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      clr_reply_in  = clr_reply_ff;
      cmd_in        = cmd_ff;
      sum1_in       = sum1_ff;
      sum2_in       = sum2_ff;
      pos_in        = pos_ff;
      edge_count_in = edge_count_ff;
      u_in          = u_ff;
      v_in          = v_ff;
      hu_in         = hu_ff;
      hv_in         = hv_ff;
      cur_in        = cur_ff;
      eu_in         = eu_ff;
      ev_in         = ev_ff;
      va_in         = va_ff;
      ee_in         = ee_ff;
      tgt_in        = tgt_ff;
      ei_in         = ei_ff;
      pass_in       = pass_ff;
      first_in      = first_ff;
      changed_in    = changed_ff;
      out_status_in = out_status_ff;
      out_index_in  = out_index_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp.ready;
      rsp_load      = 1'b0;
      req.ready     = (state_ff == ST_IDLE);
      v_rd_en   = 1'b0;
      v_rd_addr = '0;
      v_wr_en   = 1'b0;
      v_wr_addr = '0;
      v_wr_data = '0;
      e_rd_en   = 1'b0;
      e_rd_addr = '0;
      e_wr_en   = 1'b0;
      e_wr_addr = '0;
      e_wr_data = '0;
      w_rd_en   = 1'b0;
      w_rd_addr = '0;
      wa_wr_en  = 1'b0;
      wb_wr_en  = 1'b0;
      w_wr_addr = '0;
      mod_start = 1'b0;
      mod_x0    = '0;
      mod_x1    = '0;
      mod_d     = '0;
      ns1       = sum1_ff + phb_pkg::SUM_W'(wa_rd_ff);
      ns2       = sum2_ff + phb_pkg::SUM_W'(wb_rd_ff);
      msum      = '0;
      mres      = '0;

      case (state_ff)
         ST_CLR: begin
            v_wr_en   = 1'b1;
            v_wr_addr = cnt_ff[phb_pkg::VADDR_W-1:0];
            v_wr_data.sid = cnt_ff[phb_pkg::VADDR_W-1:0];
            if (cnt_ff[phb_pkg::VADDR_W-1:0] == {phb_pkg::VADDR_W{1'b1}}) begin
               cnt_in        = '0;
               out_status_in = phb_pkg::STAT_DONE;
               out_index_in  = '0;
               state_in      = clr_reply_ff ? ST_OUT : ST_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req.valid) begin
               case (req.command)
                  phb_pkg::CMD_CLEAR: begin
                     edge_count_in = '0;
                     sum1_in       = '0;
                     sum2_in       = '0;
                     pos_in        = '0;
                     cnt_in        = '0;
                     clr_reply_in  = 1'b1;
                     state_in      = ST_CLR;
                  end
                  phb_pkg::CMD_WEIGHT: begin
                     wa_wr_en      = ~req.table_select;
                     wb_wr_en      = req.table_select;
                     w_wr_addr     = {req.position, req.symbol};
                     out_status_in = phb_pkg::STAT_DONE;
                     out_index_in  = '0;
                     state_in      = ST_OUT;
                  end
                  phb_pkg::CMD_INSERT, phb_pkg::CMD_LOOKUP: begin
                     w_rd_en   = 1'b1;
                     w_rd_addr = {pos_ff[phb_pkg::POS_W-1:0], req.symbol};
                     cmd_in    = req.command;
                     state_in  = ST_SYM;
                  end
                  phb_pkg::CMD_FINAL: begin
                     cnt_in   = '0;
                     state_in = ST_F_INIT;
                  end
                  default: ;
               endcase
            end
         end
         ST_SYM: begin
            if ({1'b0, pos_ff} + 4'd1 < {1'b0, len_eff}) begin
               sum1_in  = ns1;
               sum2_in  = ns2;
               pos_in   = pos_ff + 3'd1;
               state_in = ST_IDLE;
            end else begin
               mod_start = 1'b1;
               mod_x0    = ns1;
               mod_x1    = ns2;
               mod_d     = vc_eff;
               sum1_in   = '0;
               sum2_in   = '0;
               pos_in    = '0;
               state_in  = ST_KMOD;
            end
         end
         ST_KMOD: begin
            if (mcnt_ff == 4'd0) begin
               u_in = mr_ff[0][phb_pkg::VADDR_W-1:0];
               v_in = mr_ff[1][phb_pkg::VADDR_W-1:0];
               if (cmd_ff == phb_pkg::CMD_INSERT) begin
                  if (edge_count_ff >= kc_eff) begin
                     out_status_in = phb_pkg::STAT_FULL;
                     out_index_in  = '0;
                     state_in      = ST_OUT;
                  end else begin
                     v_rd_en   = 1'b1;
                     v_rd_addr = mr_ff[0][phb_pkg::VADDR_W-1:0];
                     state_in  = ST_I_RV;
                  end
               end else begin
                  v_rd_en   = 1'b1;
                  v_rd_addr = mr_ff[0][phb_pkg::VADDR_W-1:0];
                  state_in  = ST_L_RV;
               end
            end
         end
         ST_L_RV: begin
            va_in     = v_rd_ff;
            v_rd_en   = 1'b1;
            v_rd_addr = v_ff;
            state_in  = ST_L_GET;
         end
         ST_L_GET: begin
            mod_start = 1'b1;
            mod_x0    = phb_pkg::SUM_W'(va_ff.value);
            mod_x1    = phb_pkg::SUM_W'(v_rd_ff.value);
            mod_d     = {2'b00, kc_eff};
            state_in  = ST_L_MOD;
         end
         ST_L_MOD: begin
            if (mcnt_ff == 4'd0) begin
               msum = mr_ff[0][11:0] + mr_ff[1][11:0];
               mres = (msum >= {1'b0, kc_eff}) ? msum - {1'b0, kc_eff} : msum;
               out_status_in = phb_pkg::STAT_LOOKUP;
               out_index_in  = mres[9:0];
               state_in      = ST_OUT;
            end
         end
         ST_I_RV: begin
            eu_in     = v_rd_ff;
            v_rd_en   = 1'b1;
            v_rd_addr = v_ff;
            state_in  = ST_I_WU;
         end
         ST_I_WU: begin
            ev_in     = v_rd_ff;
            v_wr_en   = 1'b1;
            v_wr_addr = u_ff;
            v_wr_data = eu_ff;
            v_wr_data.value = '0;
            state_in  = ST_I_WV;
         end
         ST_I_WV: begin
            v_wr_en   = 1'b1;
            v_wr_addr = v_ff;
            v_wr_data = ev_ff;
            v_wr_data.value = '0;
            if (eu_ff.sid == ev_ff.sid) begin
               out_status_in = phb_pkg::STAT_CYCLE;
               out_index_in  = '0;
               state_in      = ST_OUT;
            end else begin
               v_rd_en = 1'b1;
               if (ev_ff.sid < eu_ff.sid) begin
                  u_in      = v_ff;
                  v_in      = u_ff;
                  hu_in     = ev_ff.sid;
                  hv_in     = eu_ff.sid;
                  cur_in    = v_ff;
                  v_rd_addr = v_ff;
               end else begin
                  hu_in     = eu_ff.sid;
                  hv_in     = ev_ff.sid;
                  cur_in    = u_ff;
                  v_rd_addr = u_ff;
               end
               state_in = ST_I_END;
            end
         end
         ST_I_END: begin
            v_rd_en = 1'b1;
            if (v_rd_ff.lnk_v) begin
               cur_in    = v_rd_ff.lnk;
               v_rd_addr = v_rd_ff.lnk;
            end else begin
               v_wr_en   = 1'b1;
               v_wr_addr = cur_ff;
               v_wr_data = v_rd_ff;
               v_wr_data.lnk_v = 1'b1;
               v_wr_data.lnk   = hv_ff;
               cur_in    = hv_ff;
               v_rd_addr = hv_ff;
               state_in  = ST_I_REL;
            end
         end
         ST_I_REL: begin
            v_wr_en   = 1'b1;
            v_wr_addr = cur_ff;
            v_wr_data = v_rd_ff;
            v_wr_data.sid = hu_ff;
            if (v_rd_ff.lnk_v) begin
               v_rd_en   = 1'b1;
               v_rd_addr = v_rd_ff.lnk;
               cur_in    = v_rd_ff.lnk;
            end else begin
               e_wr_en   = 1'b1;
               e_wr_addr = edge_count_ff[phb_pkg::EADDR_W-1:0];
               e_wr_data.pending = 1'b0;
               e_wr_data.a = v_ff;
               e_wr_data.b = u_ff;
               out_status_in = phb_pkg::STAT_INSERT;
               out_index_in  = edge_count_ff[9:0];
               edge_count_in = edge_count_ff + 1'b1;
               state_in      = ST_OUT;
            end
         end
         ST_F_INIT: begin
            if (!cnt_ff[CNT_W-1]) begin
               v_rd_en   = 1'b1;
               v_rd_addr = cnt_ff[phb_pkg::VADDR_W-1:0];
            end
            if (cnt_ff != '0) begin
               v_wr_en   = 1'b1;
               v_wr_addr = phb_pkg::VADDR_W'(cnt_ff - 1'b1);
               v_wr_data = v_rd_ff;
               v_wr_data.value   = '0;
               v_wr_data.reached = (v_rd_ff.sid == v_wr_addr) && v_rd_ff.lnk_v;
            end
            if (cnt_ff[CNT_W-1]) begin
               ei_in      = '0;
               pass_in    = '0;
               first_in   = 1'b1;
               changed_in = 1'b0;
               state_in   = ST_F_ERD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_F_ERD: begin
            if (ei_ff == edge_count_ff) begin
               if (changed_ff && pass_ff < ECNT_W'(phb_pkg::MAX_KEYS)) begin
                  pass_in    = pass_ff + 1'b1;
                  first_in   = 1'b0;
                  changed_in = 1'b0;
                  ei_in      = '0;
               end else begin
                  out_status_in = phb_pkg::STAT_DONE;
                  out_index_in  = '0;
                  state_in      = ST_OUT;
               end
            end else begin
               e_rd_en   = 1'b1;
               e_rd_addr = ei_ff[phb_pkg::EADDR_W-1:0];
               state_in  = ST_F_EA;
            end
         end
         ST_F_EA: begin
            ee_in = e_rd_ff;
            if (first_ff || e_rd_ff.pending) begin
               v_rd_en   = 1'b1;
               v_rd_addr = e_rd_ff.a;
               state_in  = ST_F_VB;
            end else begin
               ei_in    = ei_ff + 1'b1;
               state_in = ST_F_ERD;
            end
         end
         ST_F_VB: begin
            va_in     = v_rd_ff;
            v_rd_en   = 1'b1;
            v_rd_addr = ee_ff.b;
            state_in  = ST_F_DEC;
         end
         ST_F_DEC: begin
            mod_x0 = phb_pkg::SUM_W'(ei_ff);
            mod_d  = {2'b00, kc_eff};
            if (va_ff.reached && !v_rd_ff.reached) begin
               mod_start = 1'b1;
               mod_x1    = phb_pkg::SUM_W'(va_ff.value);
               tgt_in    = 1'b1;
               eu_in     = v_rd_ff;
               state_in  = ST_F_MOD;
            end else if (v_rd_ff.reached && !va_ff.reached) begin
               mod_start = 1'b1;
               mod_x1    = phb_pkg::SUM_W'(v_rd_ff.value);
               tgt_in    = 1'b0;
               eu_in     = va_ff;
               state_in  = ST_F_MOD;
            end else begin
               e_wr_en   = 1'b1;
               e_wr_addr = ei_ff[phb_pkg::EADDR_W-1:0];
               e_wr_data = ee_ff;
               e_wr_data.pending = 1'b1;
               ei_in     = ei_ff + 1'b1;
               state_in  = ST_F_ERD;
            end
         end
         ST_F_MOD: begin
            if (mcnt_ff == 4'd0) begin
               msum = mr_ff[0][11:0] + {1'b0, kc_eff} - mr_ff[1][11:0];
               mres = (msum >= {1'b0, kc_eff}) ? msum - {1'b0, kc_eff} : msum;
               v_wr_en   = 1'b1;
               v_wr_addr = tgt_ff ? ee_ff.b : ee_ff.a;
               v_wr_data = eu_ff;
               v_wr_data.value   = mres[9:0];
               v_wr_data.reached = 1'b1;
               e_wr_en   = 1'b1;
               e_wr_addr = ei_ff[phb_pkg::EADDR_W-1:0];
               e_wr_data = ee_ff;
               e_wr_data.pending = 1'b0;
               changed_in = 1'b1;
               ei_in      = ei_ff + 1'b1;
               state_in   = ST_F_ERD;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLR;
         cnt_ff          <= '0;
         clr_reply_ff    <= 1'b0;
         sum1_ff         <= '0;
         sum2_ff         <= '0;
         pos_ff          <= '0;
         edge_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
         mcnt_ff         <= '0;
         key_count_ff    <= 11'(phb_pkg::MAX_KEYS);
         vertex_count_ff <= 13'(phb_pkg::MAX_VERTICES);
         key_length_ff   <= 3'(phb_pkg::MAX_KEY_SYMBOLS);
      end else begin
         state_ff        <= state_in;
         cnt_ff          <= cnt_in;
         clr_reply_ff    <= clr_reply_in;
         sum1_ff         <= sum1_in;
         sum2_ff         <= sum2_in;
         pos_ff          <= pos_in;
         edge_count_ff   <= edge_count_in;
         rsp_valid_ff    <= rsp_valid_in;
         mcnt_ff         <= mcnt_in;
         key_count_ff    <= key_count_in;
         vertex_count_ff <= vertex_count_in;
         key_length_ff   <= key_length_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      hu_ff         <= hu_in;
      hv_ff         <= hv_in;
      cur_ff        <= cur_in;
      eu_ff         <= eu_in;
      ev_ff         <= ev_in;
      va_ff         <= va_in;
      ee_ff         <= ee_in;
      tgt_ff        <= tgt_in;
      ei_ff         <= ei_in;
      pass_ff       <= pass_in;
      first_ff      <= first_in;
      changed_ff    <= changed_in;
      out_status_ff <= out_status_in;
      out_index_ff  <= out_index_in;
      mx_ff         <= mx_in;
      mr_ff         <= mr_in;
      md_ff         <= md_in;
      if (rsp_load) begin
         rsp_status_ff <= out_status_ff;
         rsp_index_ff  <= out_index_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v_wr_en) begin
         vert_mem[v_wr_addr] <= v_wr_data;
      end
      if (v_rd_en) begin
         if (v_wr_en && (v_wr_addr == v_rd_addr)) begin
            v_rd_ff <= v_wr_data;
         end else begin
            v_rd_ff <= vert_mem[v_rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (e_wr_en) begin
         edge_mem[e_wr_addr] <= e_wr_data;
      end
      if (e_rd_en) begin
         e_rd_ff <= edge_mem[e_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wa_wr_en) begin
         wa_mem[w_wr_addr] <= req.weight;
      end
      if (wb_wr_en) begin
         wb_mem[w_wr_addr] <= req.weight;
      end
      if (w_rd_en) begin
         wa_rd_ff <= wa_mem[w_rd_addr];
         wb_rd_ff <= wb_mem[w_rd_addr];
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.key_index = rsp_index_ff;

   // Chains never loop back, so a chain walk never writes the vertex it reads next.
   assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_I_END || state_ff == ST_I_REL) && v_wr_en && v_rd_en)
      |-> (v_wr_addr != v_rd_addr))
      else $error("chain walk reads the vertex it writes");

   assert property (@(posedge clock) disable iff (reset)
      mod_start |-> (mcnt_ff == 4'd0))
      else $error("remainder unit restarted while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp.ready))
      else $error("pending response transaction overwritten");

   assert property (@(posedge clock) disable iff (reset)
      edge_count_ff <= ECNT_W'(phb_pkg::MAX_KEYS))
      else $error("edge count beyond edge store");

endmodule

// File: test/perfect_hash_builder_lookup_unit_test.sv
`timescale 1ns / 100ps

module perfect_hash_builder_lookup_unit_test;
   import phb_pkg::*;

   localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;
   localparam int CYCLE_LIMIT = 4000000;

   typedef struct packed {
      logic [2:0]  command;
      logic [7:0]  symbol;
      logic [1:0]  position;
      logic        table_select;
      logic [11:0] weight;
   } hash_cmd_t;

   typedef struct packed {
      logic [2:0] status;
      logic [9:0] key_index;
   } hash_result_t;

   logic clock;
   logic reset;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [3:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   phb_req_if req_ch ();
   phb_rsp_if rsp_ch ();

   perfect_hash_builder_lookup_unit uut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   hash_cmd_t    pending_cmds[$];
   hash_result_t expected_results[$];
   int error_count = 0;
   int cycle_count = 0;

   // Predicted block state.
   logic [11:0] wt_a [MAX_KEY_SYMBOLS*SYMBOLS];
   logic [11:0] wt_b [MAX_KEY_SYMBOLS*SYMBOLS];
   int vval [MAX_VERTICES];
   int sid [MAX_VERTICES];
   int link [MAX_VERTICES];
   bit reached [MAX_VERTICES];
   int edge_a [MAX_KEYS];
   int edge_b [MAX_KEYS];
   bit edge_open [MAX_KEYS];
   int edge_total, sum_a, sum_b, sym_pos;
   int key_count_reg = 1024, vertex_count_reg = 4096, key_length_reg = 4;

   function automatic int eff_keys();
      if (key_count_reg == 0) return 1;
      return key_count_reg > MAX_KEYS ? MAX_KEYS : key_count_reg;
   endfunction

   function automatic int eff_vertices();
      if (vertex_count_reg == 0) return 1;
      return vertex_count_reg > MAX_VERTICES ? MAX_VERTICES : vertex_count_reg;
   endfunction

   function automatic int eff_length();
      if (key_length_reg == 0) return 1;
      return key_length_reg > MAX_KEY_SYMBOLS ? MAX_KEY_SYMBOLS : key_length_reg;
   endfunction

   function automatic void graph_clear();
      for (int i = 0; i < MAX_VERTICES; i++) begin
         vval[i] = 0;
         sid[i] = i;
         link[i] = -1;
         reached[i] = 0;
      end
      edge_total = 0;
      sum_a = 0;
      sum_b = 0;
      sym_pos = 0;
   endfunction

   function automatic int chain_tail(int nr);
      int guard = 0;
      while (link[nr] >= 0 && guard < MAX_VERTICES) begin
         nr = link[nr] % MAX_VERTICES;
         guard++;
      end
      return nr;
   endfunction

   function automatic logic [2:0] add_edge(int u, int v, output int idx);
      int head, nr, t;
      int guard = 0;
      idx = 0;
      if (edge_total >= eff_keys() || edge_total >= MAX_KEYS) return STAT_FULL;
      vval[u] = 0;
      vval[v] = 0;
      if (sid[v] < sid[u]) begin
         t = u; u = v; v = t;
      end
      head = sid[u];
      if (head == sid[v]) return STAT_CYCLE;
      nr = chain_tail(u);
      link[nr] = sid[v] % MAX_VERTICES;
      while (link[nr] >= 0 && guard < MAX_VERTICES) begin
         nr = link[nr] % MAX_VERTICES;
         sid[nr] = head;
         guard++;
      end
      edge_a[edge_total] = v;
      edge_b[edge_total] = u;
      idx = edge_total;
      edge_total++;
      return STAT_INSERT;
   endfunction

   function automatic void assign_values();
      int kc = eff_keys();
      int a, b;
      bit ra, rb;
      bit changed = 1;
      for (int i = 0; i < MAX_VERTICES; i++) begin
         reached[i] = (sid[i] == i && link[i] >= 0);
         vval[i] = 0;
      end
      for (int i = 0; i < edge_total; i++) edge_open[i] = 1;
      for (int pass = 0; changed && pass <= MAX_KEYS; pass++) begin
         changed = 0;
         for (int i = 0; i < edge_total; i++) begin
            if (edge_open[i]) begin
               a = edge_a[i];
               b = edge_b[i];
               ra = reached[a];
               rb = reached[b];
               if (ra && !rb) begin
                  vval[b] = (i % kc + kc - vval[a] % kc) % kc;
                  reached[b] = 1;
                  edge_open[i] = 0;
                  changed = 1;
               end
               if (rb && !ra) begin
                  vval[a] = (i % kc + kc - vval[b] % kc) % kc;
                  reached[a] = 1;
                  edge_open[i] = 0;
                  changed = 1;
               end
            end
         end
      end
   endfunction

   function automatic void predict_hash(hash_cmd_t c);
      hash_result_t r;
      int idx = 0;
      int at, u, v, vc, kc;
      r.status = STAT_DONE;
      case (c.command)
         CMD_CLEAR: graph_clear();
         CMD_WEIGHT: begin
            at = c.position * SYMBOLS + c.symbol;
            if (c.table_select) wt_b[at] = c.weight;
            else wt_a[at] = c.weight;
         end
         CMD_FINAL: assign_values();
         CMD_INSERT, CMD_LOOKUP: begin
            at = sym_pos * SYMBOLS + c.symbol;
            sum_a += wt_a[at];
            sum_b += wt_b[at];
            if (sym_pos + 1 < eff_length()) begin
               sym_pos++;
               return;
            end
            vc = eff_vertices();
            u = sum_a % vc;
            v = sum_b % vc;
            sum_a = 0;
            sum_b = 0;
            sym_pos = 0;
            if (c.command == CMD_INSERT) begin
               r.status = add_edge(u, v, idx);
            end else begin
               kc = eff_keys();
               r.status = STAT_LOOKUP;
               idx = (vval[u] % kc + vval[v] % kc) % kc;
            end
         end
         default: return;
      endcase
      r.key_index = idx[9:0];
      expected_results.push_back(r);
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Driver: bursts of random length with random gaps.
   int burst_left = 1, gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.command <= '0;
         req_ch.symbol <= '0;
         req_ch.position <= '0;
         req_ch.table_select <= 1'b0;
         req_ch.weight <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            predict_hash({req_ch.command, req_ch.symbol, req_ch.position,
                          req_ch.table_select, req_ch.weight});
         if (!req_ch.valid || req_ch.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_ch.valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
               hash_cmd_t c;
               c = pending_cmds.pop_front();
               req_ch.valid <= 1'b1;
               {req_ch.command, req_ch.symbol, req_ch.position,
                req_ch.table_select, req_ch.weight} <= c;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall pattern that steps through four modes in turn, plus one long hold.
   int rx_cycle = 0, hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rx_cycle++;
         if (!hold_done && pending_cmds.size() > 10 && expected_results.size() > 0) begin
            hold_done = 1;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case ((rx_cycle / 256) % 4)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= ($urandom % 4 != 0);
               2: rsp_ch.ready <= rx_cycle[0];
               default: rsp_ch.ready <= ($urandom % 4 == 0);
            endcase
         end
      end
   end

   // Monitor.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result transaction: status %0d key_index %0d",
                   rsp_ch.status, rsp_ch.key_index);
            error_count++;
         end else begin
            hash_result_t e;
            e = expected_results.pop_front();
            if (rsp_ch.status !== e.status) begin
               $error("status: expected %0d actual %0d", e.status, rsp_ch.status);
               error_count++;
            end
            if (rsp_ch.key_index !== e.key_index) begin
               $error("key_index: expected %0d actual %0d", e.key_index, rsp_ch.key_index);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Generator side.
   bit a_written [MAX_KEY_SYMBOLS*SYMBOLS];
   bit b_written [MAX_KEY_SYMBOLS*SYMBOLS];
   logic [7:0] usable_syms[$];
   logic [31:0] stored_keys[$];
   int gen_length = 4;

   task automatic send(logic [2:0] cmd, logic [7:0] sym = 0, logic [1:0] pos = 0,
                       logic sel = 0, logic [11:0] w = 0);
      hash_cmd_t c;
      c = '{cmd, sym, pos, sel, w};
      pending_cmds.push_back(c);
   endtask

   task automatic write_weight(logic [7:0] sym, logic [1:0] pos, logic sel, logic [11:0] w);
      int at;
      bit all_set = 1;
      at = pos * SYMBOLS + sym;
      send(CMD_WEIGHT, sym, pos, sel, w);
      if (sel) b_written[at] = 1;
      else a_written[at] = 1;
      for (int p = 0; p < MAX_KEY_SYMBOLS; p++)
         if (!a_written[p*SYMBOLS+sym] || !b_written[p*SYMBOLS+sym]) all_set = 0;
      if (all_set && !(sym inside {usable_syms})) usable_syms.push_back(sym);
   endtask

   function automatic logic [7:0] any_sym();
      return usable_syms[$urandom_range(0, usable_syms.size() - 1)];
   endfunction

   task automatic send_key(logic [2:0] last_cmd, bit mixed, logic [31:0] syms);
      logic [2:0] cmd;
      for (int k = 0; k < gen_length; k++) begin
         cmd = last_cmd;
         if (mixed && k + 1 < gen_length) cmd = ($urandom % 2) ? CMD_INSERT : CMD_LOOKUP;
         send(cmd, syms[8*k +: 8]);
      end
   endtask

   function automatic logic [31:0] rand_key();
      logic [31:0] k;
      for (int i = 0; i < 4; i++) k[8*i +: 8] = any_sym();
      return k;
   endfunction

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || req_ch.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      case (idx)
         REG_KEY_COUNT: key_count_reg = value[10:0];
         REG_VERTEX_COUNT: vertex_count_reg = value[12:0];
         default: key_length_reg = value[2:0];
      endcase
   endtask

   task automatic configure(int kc, int vc, int kl);
      wait_drained();
      csr_write(REG_KEY_COUNT, kc);
      csr_write(REG_VERTEX_COUNT, vc);
      csr_write(REG_KEY_LENGTH, kl);
      gen_length = eff_length();
      stored_keys.delete();
      send(CMD_CLEAR);
   endtask

   task automatic random_phase(int count);
      int r, n;
      logic [31:0] k;
      for (int i = 0; i < 6; i++)
         write_weight($urandom, $urandom, $urandom, $urandom);
      n = 0;
      while (n < count) begin
         r = $urandom % 100;
         if (r < 50) begin
            k = rand_key();
            send_key(CMD_INSERT, 0, k);
            if (stored_keys.size() < 40) stored_keys.push_back(k);
         end else if (r < 62) begin
            send_key(CMD_LOOKUP, 0, rand_key());
         end else if (r < 68) begin
            send_key(($urandom % 2) ? CMD_INSERT : CMD_LOOKUP, 1, rand_key());
         end else if (r < 80 && stored_keys.size() > 0) begin
            send_key(CMD_LOOKUP, 0, stored_keys[$urandom_range(0, stored_keys.size() - 1)]);
         end else if (r < 84) begin
            send($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST), $urandom, $urandom,
                 $urandom, $urandom);
            n--;
         end else if (r < 90) begin
            write_weight(any_sym(), $urandom, $urandom, $urandom);
         end else if (r < 92) begin
            send(CMD_FINAL);
         end else if (r < 93) begin
            if (gen_length > 1) send(CMD_INSERT, any_sym());
            send(CMD_CLEAR);
            stored_keys.delete();
         end else begin
            k = rand_key();
            send_key(CMD_INSERT, 0, k);
         end
         n += gen_length;
      end
      send(CMD_FINAL);
      foreach (stored_keys[i]) send_key(CMD_LOOKUP, 0, stored_keys[i]);
      send(CMD_FINAL);
      if (stored_keys.size() > 0) send_key(CMD_LOOKUP, 0, stored_keys[0]);
   endtask

   initial begin
      logic [7:0] base_syms[12];
      int kc, vc, kl;
      base_syms = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40,
                    8'h80, 8'h55, 8'hAA};
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Weight load for a base set of symbols, extremes of the weight field included.
      foreach (base_syms[i])
         for (int p = 0; p < MAX_KEY_SYMBOLS; p++) begin
            write_weight(base_syms[i], p, 0, (i == 0) ? 12'h000 : (i == 1) ? 12'hFFF : $urandom);
            write_weight(base_syms[i], p, 1, (i == 0) ? 12'hFFF : (i == 1) ? 12'h000 : $urandom);
         end

      // Directed part at the reset configuration.
      send(CMD_CLEAR);
      send_key(CMD_INSERT, 0, 32'h00000000);
      send_key(CMD_INSERT, 0, 32'hFFFFFFFF);
      send_key(CMD_INSERT, 0, 32'h00000000);
      send_key(CMD_LOOKUP, 0, 32'hFFFFFFFF);
      send(CMD_FINAL);
      send_key(CMD_LOOKUP, 0, 32'h00000000);
      send(CMD_FINAL);
      send_key(CMD_LOOKUP, 0, 32'hFFFFFFFF);
      send(CMD_RESERVED_FIRST, 8'hFF, 2'd3, 1'b1, 12'hFFF);
      send(CMD_RESERVED_LAST);
      send(CMD_INSERT, 8'h55);
      send(CMD_LOOKUP, 8'hAA);
      send(CMD_INSERT, 8'h01);
      send(CMD_LOOKUP, 8'h80);
      send(CMD_INSERT, 8'h02);
      send(CMD_CLEAR);
      send_key(CMD_LOOKUP, 0, 32'h55AA0102);

      // Self loops and a full edge store.
      configure(1, 1, 1);
      send(CMD_INSERT, 8'h00);
      send(CMD_INSERT, 8'hFF);
      configure(1, 2, 1);
      for (int i = 0; i < 6; i++) send(CMD_INSERT, any_sym());
      send(CMD_FINAL);
      send(CMD_LOOKUP, 8'h00);

      configure(2047, 8191, 7);
      random_phase(90);
      configure(0, 0, 0);
      random_phase(40);
      configure(1024, 16, 1);
      random_phase(90);
      configure(4, 8, 2);
      random_phase(90);
      configure(1024, 4096, 4);
      random_phase(120);
      for (int ph = 0; ph < 8; ph++) begin
         kc = $urandom_range(1, 64);
         vc = $urandom_range(1, 3) == 1 ? $urandom_range(1, 4096) : $urandom_range(2, 160);
         kl = $urandom_range(1, 4);
         configure(kc, vc, kl);
         random_phase(120);
      end

      wait_drained();
      repeat (200) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
src/phb_pkg.sv
src/phb_req_if.sv
src/phb_rsp_if.sv
src/perfect_hash_builder_lookup_unit.sv
test/perfect_hash_builder_lookup_unit_test.sv
